FILE: src/brle_pkg.sv
// Package for the bit run-length encoder: payload structs of both channels,
// the item that travels from the front end to the scanner, and queue sizing.
// No dependencies.
package brle_pkg;

   // Input beat: one byte of the stream, bit 7 scanned first.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } brle_req_type;

   // Output beat: one run record.
   typedef struct packed {
      logic       out_bit;
      logic [6:0] out_length;
      logic       item_done;
      logic       stream_end;
   } brle_rsp_type;

   // Classified byte: later_chg[p] is set when some bit below position p
   // differs from its upper neighbor, i.e. the byte closes a run after p.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic [7:0] later_chg;
   } brle_item_type;

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [2:0] BitPosFirst = 3'd7;
   localparam logic [2:0] BitPosLast  = 3'd0;

endpackage

FILE: src/brle_front.sv
// Front end of the bit run-length encoder: input register that takes byte
// beats and marks, per bit position, whether a run change follows below it.
// Depends on brle_pkg.
module brle_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  brle_pkg::brle_req_type req_data,
   output logic                   item_valid,
   input  logic                   item_full,
   output brle_pkg::brle_item_type item_data
);
   import brle_pkg::*;

   function automatic logic [7:0] later_changes(input logic [7:0] d);
      logic [7:0] m;
      m[0] = 1'b0;
      for (int p = 1; p < 8; p++) begin
         m[p] = m[p-1] | (d[p-1] ^ d[p]);
      end
      return m;
   endfunction

   logic          front_valid_ff, front_valid_in;
   brle_item_type front_item_ff, front_item_in;
   logic          push;
   logic          load;

   assign push      = front_valid_ff && !item_full;
   assign req_stall = front_valid_ff && !push;
   assign load      = !req_stall;

   always_comb begin
      front_valid_in = load ? req_valid : front_valid_ff;
      front_item_in  = front_item_ff;
      if (load && req_valid) begin
         front_item_in.data_byte = req_data.data_byte;
         front_item_in.last_byte = req_data.last_byte;
         front_item_in.later_chg = later_changes(req_data.data_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_item_ff <= front_item_in;
   end

   assign item_valid = front_valid_ff;
   assign item_data  = front_item_ff;

endmodule

FILE: src/brle_queue.sv
// Short FIFO between the front end and the run scanner of the bit
// run-length encoder. Depends on brle_pkg.
module brle_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  brle_pkg::brle_item_type push_data,
   output logic                    full,
   output logic                    head_valid,
   output brle_pkg::brle_item_type head_data,
   input  logic                    pop
);
   import brle_pkg::*;

   localparam logic [QueuePtrW-1:0] PtrLast = QueuePtrW'(QueueDepth - 1);
   localparam logic [QueueCntW-1:0] CntFull = QueueCntW'(QueueDepth);

   brle_item_type          entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/brle_back.sv
// Run scanner of the bit run-length encoder: walks one bit of the head byte
// per cycle while the output register can take a record, keeps the open run
// and drives the registered record output. Depends on brle_pkg.
module brle_back #(
   parameter int unsigned RUN_MAX = 127
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  brle_pkg::brle_item_type head_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output brle_pkg::brle_rsp_type  rsp_data
);
   import brle_pkg::*;

   localparam logic [6:0] RunMaxLen = 7'(RUN_MAX);

   logic         run_bit_ff, run_bit_in;
   logic [6:0]   run_len_ff, run_len_in;
   logic [2:0]   pos_ff, pos_in;
   logic         flush_ff, flush_in;
   logic         rsp_valid_ff, rsp_valid_in;
   brle_rsp_type rsp_data_ff, rsp_data_in;

   logic         out_free;
   logic         step;
   logic         cur_bit;
   logic         eff_bit;
   logic         emit;
   logic         rec_bit;
   logic [6:0]   rec_len;
   logic         rec_done;
   logic         rec_end;

   // Scanner advances only when the output register can take a record.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step     = head_valid && out_free;
   assign cur_bit  = head_data.data_byte[pos_ff];
   // With no run open, the first bit of the byte opens it.
   assign eff_bit  = (run_len_ff == '0) ? cur_bit : run_bit_ff;

   always_comb begin
      run_bit_in = run_bit_ff;
      run_len_in = run_len_ff;
      pos_in     = pos_ff;
      flush_in   = flush_ff;
      pop        = 1'b0;
      emit       = 1'b0;
      rec_bit    = eff_bit;
      rec_len    = run_len_ff;
      rec_done   = 1'b0;
      rec_end    = 1'b0;

      if (step) begin
         if (flush_ff) begin
            emit       = 1'b1;
            rec_bit    = run_bit_ff;
            rec_len    = run_len_ff;
            rec_done   = 1'b1;
            rec_end    = 1'b1;
            run_bit_in = 1'b0;
            run_len_in = '0;
            flush_in   = 1'b0;
            pos_in     = BitPosFirst;
            pop        = 1'b1;
         end else begin
            run_bit_in = eff_bit;
            if (cur_bit == eff_bit) begin
               if (run_len_ff >= RunMaxLen) begin
                  emit       = 1'b1;
                  rec_len    = RunMaxLen;
                  run_len_in = 7'd1;
               end else begin
                  run_len_in = run_len_ff + 7'd1;
               end
            end else begin
               emit       = 1'b1;
               rec_len    = run_len_ff;
               run_bit_in = cur_bit;
               run_len_in = 7'd1;
            end
            // A record at this position is the byte's last unless a change
            // lies below, the fresh run can still hit the maximum, or a
            // flush follows.
            rec_done = !head_data.last_byte && !head_data.later_chg[pos_ff]
                       && ({4'd0, pos_ff} < RunMaxLen);
            if (pos_ff == BitPosLast) begin
               pos_in = BitPosFirst;
               if (head_data.last_byte) begin
                  flush_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               pos_in = pos_ff - 3'd1;
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_data_in.out_bit    = rec_bit;
         rsp_data_in.out_length = rec_len;
         rsp_data_in.item_done  = rec_done;
         rsp_data_in.stream_end = rec_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_bit_ff   <= 1'b0;
         run_len_ff   <= '0;
         pos_ff       <= BitPosFirst;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_bit_ff   <= run_bit_in;
         run_len_ff   <= run_len_in;
         pos_ff       <= pos_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/bit_run_length_encoder.sv
// Bit run-length encoder. Bytes enter on the req_ channel, bit 7 first, and
// leave as run records (bit value, length 1..RUN_MAX) on the rsp_ channel;
// a byte flagged last_byte flushes the open run with stream_end set, and
// item_done marks the last record a byte causes. The scanner handles one
// bit per clock, walking all eight bits of a byte plus a flush step for a
// last byte, and records leave at most one per cycle from an output
// register. A two-entry queue sits in front of the scanner, so bytes keep
// arriving while it works; back-pressure on rsp_stall halts the scanner.
// Depends on brle_pkg, brle_front, brle_queue and brle_back.
module bit_run_length_encoder #(
   parameter int unsigned RUN_MAX = 127
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  brle_pkg::brle_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output brle_pkg::brle_rsp_type rsp_data
);
   import brle_pkg::*;

   logic          push_valid;
   brle_item_type push_data;
   logic          queue_full;
   logic          head_valid;
   brle_item_type head_data;
   logic          head_pop;

   brle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (push_valid),
      .item_full  (queue_full),
      .item_data  (push_data)
   );

   brle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (head_pop)
   );

   brle_back #(
      .RUN_MAX (RUN_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   a_end_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_end |-> rsp_data.item_done)
      else $error("stream_end record without item_done");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_length != 7'd0) &&
                    ({25'd0, rsp_data.out_length} <= RUN_MAX))
      else $error("record length out of range");

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("scanner retired a byte from an empty queue");
`endif

endmodule
